// ===== rtl/core/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg: shared types and constants of the positional list engine
// Holds the list capacity, request and status codes and the cell control word.
// ----------------------------------------------------------------------------
package ple_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 8;
	localparam int DATA_W   = 32;

	typedef enum logic [1:0] {
		REQ_READ   = 2'd0,
		REQ_WRITE  = 2'd1,
		REQ_INSERT = 2'd2,
		REQ_REMOVE = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	// What every cell does with its entry in the current cycle.
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_WRITE  = 2'd1,
		CELL_INSERT = 2'd2,
		CELL_REMOVE = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		logic [IDX_W-1:0]   idx;
	} cell_ctl_t;

endpackage

// ===== rtl/core/ple_req_if.sv =====
// ----------------------------------------------------------------------------
// ple_req_if: request channel of the positional list engine
// Valid/ready handshake carrying the request type, position and value.
// ----------------------------------------------------------------------------
interface ple_req_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          req_type;
	logic [ple_pkg::POS_W-1:0]           position;
	logic signed [ple_pkg::DATA_W-1:0]   value;

	modport source (output valid, output req_type, output position, output value,
		input ready);
	modport sink (input valid, input req_type, input position, input value,
		output ready);
endinterface

// ===== rtl/core/ple_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ple_rsp_if: response channel of the positional list engine
// Valid/ready handshake carrying status, read value, count and empty flag.
// ----------------------------------------------------------------------------
interface ple_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          status;
	logic signed [ple_pkg::DATA_W-1:0]   read_value;
	logic [ple_pkg::POS_W-1:0]           item_count;
	logic                                is_empty;

	modport source (output valid, output status, output read_value,
		output item_count, output is_empty, input ready);
	modport sink (input valid, input status, input read_value,
		input item_count, input is_empty, output ready);
endinterface

// ===== rtl/core/positional_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine_core: bounded ordered list with positional access
// Reads, overwrites, inserts before or removes the entry at a 1-based position
// in a list of up to sixteen 32-bit signed values held in a row of cells.
// ----------------------------------------------------------------------------
//
//   channel | dir | payload                                      | handshake
//   --------+-----+----------------------------------------------+----------
//   req     | in  | req_type, position, value                    | valid/ready
//   rsp     | out | status, read_value, item_count, is_empty     | valid/ready
//
// All cells shift in parallel, so an insert or a remove moves the whole tail
// of the list at the same clock edge that a read or an overwrite would use.
// The response is registered. A new item is taken whenever the response
// register is empty or is being drained in the same cycle, so items flow
// back to back while the sink keeps up. Reset clears the count and the
// response valid; the entries need no reset because a position is only read
// after it has been written.
// ----------------------------------------------------------------------------
module positional_list_engine_core (
	input  logic      clk,
	input  logic      arst_n,
	ple_req_if.sink   req,
	ple_rsp_if.source rsp
);

	localparam int N = ple_pkg::CAPACITY;

	logic [ple_pkg::CNT_W-1:0]          count_q;
	logic [ple_pkg::CNT_W-1:0]          count_d;
	logic                               rsp_valid_q;
	logic [1:0]                         status_q;
	logic signed [ple_pkg::DATA_W-1:0]  rd_q;

	logic                               accept;
	logic [ple_pkg::POS_W:0]            pos_ext;
	logic [ple_pkg::POS_W:0]            cnt_ext;
	logic                               pos_nonzero;
	logic                               pos_ok;
	logic                               full;
	ple_pkg::status_t                   status_d;
	ple_pkg::cell_ctl_t                 ctl;
	logic [ple_pkg::POS_W-1:0]          pos_m1;
	logic                               do_read;

	logic signed [ple_pkg::DATA_W-1:0]  entries [N];
	logic signed [ple_pkg::DATA_W-1:0]  rd_chain [N+1];

	// The engine stalls only when its response register is full and not drained.
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	// Range checks run on one extra bit so count + 1 never wraps.
	assign pos_ext     = {1'b0, req.position};
	assign cnt_ext     = (ple_pkg::POS_W + 1)'(count_q);
	assign pos_nonzero = (req.position != '0);
	assign full        = (count_q == ple_pkg::CNT_W'(N));
	assign pos_m1      = req.position - ple_pkg::POS_W'(1);

	always_comb begin
		if (req.req_type == ple_pkg::REQ_INSERT) begin
			pos_ok = pos_nonzero && (pos_ext <= cnt_ext + (ple_pkg::POS_W + 1)'(1));
		end else begin
			pos_ok = pos_nonzero && (pos_ext <= cnt_ext);
		end
	end

	// Decode the request into one control word that every cell sees. A failed
	// request holds all cells, so the list stays as it was.
	always_comb begin
		status_d = ple_pkg::ST_OK;
		ctl.op   = ple_pkg::CELL_HOLD;
		ctl.idx  = pos_m1[ple_pkg::IDX_W-1:0];
		count_d  = count_q;
		do_read  = 1'b0;
		if (!pos_ok) begin
			status_d = ple_pkg::ST_BADPOS;
		end else begin
			case (req.req_type)
				ple_pkg::REQ_READ: begin
					do_read = 1'b1;
				end
				ple_pkg::REQ_WRITE: begin
					ctl.op = ple_pkg::CELL_WRITE;
				end
				ple_pkg::REQ_INSERT: begin
					if (full) begin
						status_d = ple_pkg::ST_FULL;
					end else begin
						ctl.op  = ple_pkg::CELL_INSERT;
						count_d = count_q + ple_pkg::CNT_W'(1);
					end
				end
				ple_pkg::REQ_REMOVE: begin
					ctl.op  = ple_pkg::CELL_REMOVE;
					count_d = count_q - ple_pkg::CNT_W'(1);
				end
				default: begin
					status_d = ple_pkg::ST_BADPOS;
				end
			endcase
		end
		if (!accept) begin
			ctl.op = ple_pkg::CELL_HOLD;
		end
	end

	// The read chain starts at zero; the selected cell replaces the value
	// passing through it, so the chain end carries the entry at the position.
	assign rd_chain[0] = '0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic signed [ple_pkg::DATA_W-1:0] left_v;
		logic signed [ple_pkg::DATA_W-1:0] right_v;

		if (i == 0) begin : g_first
			assign left_v = '0;
		end else begin : g_mid_l
			assign left_v = entries[i-1];
		end

		if (i == N - 1) begin : g_last
			assign right_v = '0;
		end else begin : g_mid_r
			assign right_v = entries[i+1];
		end

		ple_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.idx      (ple_pkg::IDX_W'(i)),
			.wr_value (req.value),
			.left     (left_v),
			.right    (right_v),
			.rd_in    (rd_chain[i]),
			.entry    (entries[i]),
			.rd_out   (rd_chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload; the count after the request is count_q once loaded.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			rd_q     <= do_read ? rd_chain[N] : '0;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = status_q;
	assign rsp.read_value = rd_q;
	assign rsp.item_count = ple_pkg::POS_W'(count_q);
	assign rsp.is_empty   = (count_q == '0);

endmodule

// ===== rtl/core/ple_cell.sv =====
// ----------------------------------------------------------------------------
// ple_cell: one list entry of the cell chain
// Holds one value, takes its left or right neighbor on insert or remove, and
// puts its value on the read chain in place of the incoming one when selected.
// ----------------------------------------------------------------------------
module ple_cell (
	input  logic                                clk,
	input  ple_pkg::cell_ctl_t                  ctl,
	input  logic [ple_pkg::IDX_W-1:0]           idx,
	input  logic signed [ple_pkg::DATA_W-1:0]   wr_value,
	input  logic signed [ple_pkg::DATA_W-1:0]   left,
	input  logic signed [ple_pkg::DATA_W-1:0]   right,
	input  logic signed [ple_pkg::DATA_W-1:0]   rd_in,
	output logic signed [ple_pkg::DATA_W-1:0]   entry,
	output logic signed [ple_pkg::DATA_W-1:0]   rd_out
);

	logic signed [ple_pkg::DATA_W-1:0] entry_q;
	logic signed [ple_pkg::DATA_W-1:0] entry_d;
	logic                              here;
	logic                              above;

	assign here  = (idx == ctl.idx);
	assign above = (idx > ctl.idx);

	always_comb begin
		entry_d = entry_q;
		case (ctl.op)
			ple_pkg::CELL_WRITE: begin
				if (here) entry_d = wr_value;
			end
			ple_pkg::CELL_INSERT: begin
				if (here) entry_d = wr_value;
				else if (above) entry_d = left;
			end
			ple_pkg::CELL_REMOVE: begin
				if (here || above) entry_d = right;
			end
			default: entry_d = entry_q;
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign entry  = entry_q;
	assign rd_out = here ? entry_q : rd_in;

endmodule

// ===== verif/list_response_checker.sv =====
// ----------------------------------------------------------------------------
// list_response_checker: response checker of the positional list engine
// Keeps its own copy of the list, works out the response of every accepted
// request and compares each accepted response with the oldest one in line.
// ----------------------------------------------------------------------------
module list_response_checker
	import ple_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	ple_req_if   req,
	ple_rsp_if   rsp,
	output int   fail_count,
	output int   open_results
);

	typedef struct packed {
		status_t                  status;
		logic signed [DATA_W-1:0] read_value;
		logic [POS_W-1:0]         item_count;
		logic                     is_empty;
	} list_result_t;

	logic signed [DATA_W-1:0] list_vals [CAPACITY];
	int                       list_len;
	list_result_t             pending_results [$];
	int                       errs = 0;

	// Applies one request to the local list and returns the response it gives.
	function automatic list_result_t apply_list_op(req_type_t op, logic [POS_W-1:0] pos,
		logic signed [DATA_W-1:0] val);
		list_result_t r;
		int           top_pos;
		r.status     = ST_OK;
		r.read_value = '0;
		top_pos = (op == REQ_INSERT) ? list_len + 1 : list_len;
		if (pos == 0 || pos > top_pos) begin
			r.status = ST_BADPOS;
		end else begin
			case (op)
				REQ_INSERT: begin
					if (list_len >= CAPACITY) begin
						r.status = ST_FULL;
					end else begin
						for (int i = list_len; i > pos - 1; i--)
							list_vals[i] = list_vals[i-1];
						list_vals[pos-1] = val;
						list_len++;
					end
				end
				REQ_READ: begin
					r.read_value = list_vals[pos-1];
				end
				REQ_WRITE: begin
					list_vals[pos-1] = val;
				end
				REQ_REMOVE: begin
					for (int i = pos - 1; i + 1 < list_len; i++)
						list_vals[i] = list_vals[i+1];
					list_len--;
				end
			endcase
		end
		r.item_count = POS_W'(list_len);
		r.is_empty   = (list_len == 0);
		return r;
	endfunction

	// The response side is handled first: a response never belongs to the
	// request accepted at the same edge.
	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		list_result_t got;
		if (!arst_n) begin
			pending_results.delete();
			list_len = 0;
			fail_count   <= 0;
			open_results <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got.status     = status_t'(rsp.status);
				got.read_value = rsp.read_value;
				got.item_count = rsp.item_count;
				got.is_empty   = rsp.is_empty;
				if (pending_results.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("%0t: response with no request waiting for it", $time);
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						errs++;
						if (errs <= 10)
							$display({"%0t: response mismatch (exp/got) status %0d/%0d",
								" read_value %0d/%0d item_count %0d/%0d is_empty %0d/%0d"},
								$time, want.status, got.status, want.read_value,
								got.read_value, want.item_count, got.item_count,
								want.is_empty, got.is_empty);
					end
				end
			end
			if (req.valid && req.ready)
				pending_results.push_back(apply_list_op(req_type_t'(req.req_type),
					req.position, req.value));
			fail_count   <= errs;
			open_results <= pending_results.size();
		end
	end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for positional_list_engine_core
// Drives a directed pass over the list's corner cases and then about eleven
// hundred random requests with random gaps and response stalls; the checker
// beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module testbench;
	import ple_pkg::*;

	localparam int IDLE_LIMIT   = 3000;
	localparam int RANDOM_ITEMS = 1100;
	localparam int HOLD_AFTER   = 500;
	localparam int HOLD_CYCLES  = 150;

	logic clk = 1'b0;
	logic arst_n;

	ple_req_if req ();
	ple_rsp_if rsp ();

	int fail_count;
	int open_results;

	// Number of requests accepted so far, and the list length they imply.
	// The length only steers the choice of positions; checking is done by
	// the checker's own copy of the list.
	int items_sent = 0;
	int list_len   = 0;

	// When set, the request side sends back to back with no gaps.
	logic no_gaps = 1'b0;

	positional_list_engine_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	list_response_checker checker_inst (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.rsp          (rsp),
		.fail_count   (fail_count),
		.open_results (open_results)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Gap lengths: mostly none or short, now and then a long one.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	// Values lean on the extremes of the signed range now and then.
	function automatic logic signed [DATA_W-1:0] rand_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'sd0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// Offers one item and holds it until the block takes it. The valid stays
	// high into the next item when no gap follows, so it is never lowered and
	// raised within one time step.
	task automatic send_item(input req_type_t op, input logic [POS_W-1:0] pos,
		input logic signed [DATA_W-1:0] val);
		int gap;
		int top_pos;
		req.valid    <= 1'b1;
		req.req_type <= op;
		req.position <= pos;
		req.value    <= val;
		do
			@(posedge clk);
		while (!req.ready);
		items_sent++;
		top_pos = (op == REQ_INSERT) ? list_len + 1 : list_len;
		if (pos >= 1 && pos <= top_pos) begin
			if (op == REQ_INSERT && list_len < CAPACITY)
				list_len++;
			else if (op == REQ_REMOVE)
				list_len--;
		end
		gap = no_gaps ? 0 : idle_len();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// One random item. Most items are well formed with a position inside the
	// list, so the list really grows and shrinks; about one in ten is noise
	// with any operation and any position, which mostly hits the bad position
	// check. The grow flag tilts the mix toward inserts or toward removes.
	task automatic send_random(input logic grow);
		int        r;
		req_type_t op;
		int        pos;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			send_item(req_type_t'($urandom_range(0, 3)), POS_W'($urandom_range(0, 255)),
				rand_value());
		end else begin
			r = $urandom_range(0, 99);
			if (r < (grow ? 50 : 10))
				op = REQ_INSERT;
			else if (r < 60)
				op = REQ_REMOVE;
			else if (r < 80)
				op = REQ_READ;
			else
				op = REQ_WRITE;
			if (op == REQ_INSERT)
				pos = $urandom_range(1, list_len + 1);
			else if (list_len == 0)
				pos = 1;
			else
				pos = $urandom_range(1, list_len);
			// Now and then aim at the very edge of the valid range.
			if ($urandom_range(0, 19) == 0)
				pos = (op == REQ_INSERT) ? list_len + 1 : list_len;
			send_item(op, POS_W'(pos), rand_value());
		end
	endtask

	// Response side: ready alternates between random busy and idle runs. Once,
	// after enough items, it holds off for a long stretch while the sender keeps
	// offering, so the response register fills and the request side stalls.
	initial begin
		int   run_left;
		logic on;
		logic held_off;
		rsp.ready = 1'b0;
		run_left  = 0;
		on        = 1'b0;
		held_off  = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			@(posedge clk);
			if (!held_off && items_sent >= HOLD_AFTER) begin
				on       = 1'b0;
				run_left = HOLD_CYCLES;
				held_off = 1'b1;
			end else if (run_left <= 0) begin
				on = !on;
				if (!on)
					run_left = idle_len();
				if (on || run_left == 0) begin
					on       = 1'b1;
					run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
						: $urandom_range(1, 8);
				end
			end
			rsp.ready <= on;
			run_left--;
		end
	end

	// Watchdog: a run that stops accepting anything on both channels is hung.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("positional_list_engine_core test failed");
				$finish;
			end
		end
	end

	initial begin
		logic grow;
		arst_n       = 1'b0;
		req.valid    = 1'b0;
		req.req_type = REQ_READ;
		req.position = '0;
		req.value    = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. On the empty list every position is out of range,
		// except that an insert may use position one.
		send_item(REQ_READ, 1, 0);
		send_item(REQ_REMOVE, 1, 0);
		send_item(REQ_INSERT, 0, 5);
		send_item(REQ_INSERT, 2, 5);
		// Build a short list with the extreme values: first entry, append
		// at count plus one, then insert at the front.
		send_item(REQ_INSERT, 1, 32'sh7fffffff);
		send_item(REQ_INSERT, 2, 32'sh80000000);
		send_item(REQ_INSERT, 1, -32'sd1);
		send_item(REQ_READ, 1, 32'sh7fffffff);
		send_item(REQ_READ, 3, 0);
		// Overwrite the last entry, then try positions zero and the top code.
		send_item(REQ_WRITE, 3, 0);
		send_item(REQ_READ, 3, 0);
		send_item(REQ_WRITE, 0, 1);
		send_item(REQ_WRITE, 255, 1);
		// Read and remove one past the end are out of range.
		send_item(REQ_READ, 4, 0);
		send_item(REQ_REMOVE, 4, 0);
		// Remove from the middle closes the gap.
		send_item(REQ_REMOVE, 2, 0);
		send_item(REQ_READ, 2, 0);
		// Fill the list up to capacity by appending.
		while (list_len < CAPACITY)
			send_item(REQ_INSERT, POS_W'(list_len + 1), rand_value());
		// Full list: a valid insert reports full; a bad position is reported
		// as such even though the list is full.
		send_item(REQ_INSERT, 5, 1);
		send_item(REQ_INSERT, POS_W'(CAPACITY + 1), 1);
		send_item(REQ_INSERT, POS_W'(CAPACITY + 2), 1);
		send_item(REQ_READ, POS_W'(CAPACITY), 0);
		send_item(REQ_REMOVE, POS_W'(CAPACITY), 0);
		send_item(REQ_REMOVE, 1, 0);

		// Random part. The list swings between full and empty; every so
		// often a stretch goes back to back with no gaps.
		grow = 1'b1;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			no_gaps = ((n % 150) < 30);
			if (list_len == CAPACITY && $urandom_range(0, 3) == 0)
				grow = 1'b0;
			else if (list_len == 0 && $urandom_range(0, 3) == 0)
				grow = 1'b1;
			else if ($urandom_range(0, 39) == 0)
				grow = !grow;
			send_random(grow);
		end
		req.valid <= 1'b0;

		// Let the checker take in the last request, wait for every response,
		// then leave room for any stray response before the verdict.
		@(posedge clk);
		while (open_results != 0) @(posedge clk);
		repeat (5) @(posedge clk);

		if (fail_count == 0 && open_results == 0)
			$display("positional_list_engine_core test passed");
		else
			$display("positional_list_engine_core test failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/ple_pkg.sv
rtl/core/ple_req_if.sv
rtl/core/ple_rsp_if.sv
rtl/core/ple_cell.sv
rtl/core/positional_list_engine_core.sv
verif/list_response_checker.sv
verif/testbench.sv
